[rtl/sstr_pkg.sv]
// ----------------------------------------------------------------------------
// sstr_pkg: shared types, constants and microcode for the small-state twister
// Holds the generator sizes, the item structs, the control word format, the
// microprogram table and the tempering function.
// ----------------------------------------------------------------------------
package sstr_pkg;

  localparam int STATE_WORDS      = 19;
  localparam int TAP_OFFSET       = 9;
  localparam int OUTPUTS_PER_SEED = 4;

  localparam int IDX_W  = $clog2(STATE_WORDS);
  localparam int OCNT_W = ($clog2(OUTPUTS_PER_SEED) < 2) ? 2 : $clog2(OUTPUTS_PER_SEED);
  localparam int UPC_W  = 3;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W:0]    TAP_OFF  = (IDX_W + 1)'(TAP_OFFSET);
  localparam logic [IDX_W:0]    N_WIDE   = (IDX_W + 1)'(STATE_WORDS);
  localparam logic [OCNT_W-1:0] LAST_OUT = OCNT_W'(OUTPUTS_PER_SEED - 1);

  localparam logic [31:0] SEED_MULT  = 32'd1812433253;
  localparam logic [31:0] UPPER_MASK = 32'hFFFF_FFFE;
  localparam logic [31:0] LOWER_MASK = 32'h0000_0001;
  localparam int          INIT_SHIFT = 30;
  localparam int          TEMPER_U   = 12;
  localparam int          TEMPER_S   = 7;
  localparam int          TEMPER_T   = 15;
  localparam int          TEMPER_L   = 18;

  typedef struct packed {
    logic [31:0] seed;
    logic [31:0] twist_word;
    logic [31:0] mask_b;
    logic [31:0] mask_c;
  } in_item_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic [1:0]  word_index;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_EXP_MUL,
    OP_EXP_ADD,
    OP_RD_NEXT,
    OP_RD_TAP,
    OP_TWIST
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_START,
    COND_EXP_MORE,
    COND_OUT_MORE
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             fin;
  } ucode_t;

  typedef struct packed {
    logic exp_more;
    logic out_more;
  } dp_status_t;

  localparam logic [UPC_W-1:0] UPC_IDLE  = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_MUL   = UPC_W'(1);
  localparam logic [UPC_W-1:0] UPC_ADD   = UPC_W'(2);
  localparam logic [UPC_W-1:0] UPC_RDN   = UPC_W'(3);
  localparam logic [UPC_W-1:0] UPC_RDT   = UPC_W'(4);
  localparam logic [UPC_W-1:0] UPC_TWIST = UPC_W'(5);

  // A taken condition jumps to target; otherwise fin returns to idle and a
  // clear fin falls through to the next step.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    case (upc)
      UPC_IDLE:  w = '{op: OP_LOAD,    cond: COND_START,    target: UPC_MUL, fin: 1'b1};
      UPC_MUL:   w = '{op: OP_EXP_MUL, cond: COND_NONE,     target: UPC_IDLE, fin: 1'b0};
      UPC_ADD:   w = '{op: OP_EXP_ADD, cond: COND_EXP_MORE, target: UPC_MUL, fin: 1'b0};
      UPC_RDN:   w = '{op: OP_RD_NEXT, cond: COND_NONE,     target: UPC_IDLE, fin: 1'b0};
      UPC_RDT:   w = '{op: OP_RD_TAP,  cond: COND_NONE,     target: UPC_IDLE, fin: 1'b0};
      UPC_TWIST: w = '{op: OP_TWIST,   cond: COND_OUT_MORE, target: UPC_RDN, fin: 1'b1};
      default:   w = '{op: OP_NOP,     cond: COND_NONE,     target: UPC_IDLE, fin: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] y_in,
                                         input logic [31:0] mb,
                                         input logic [31:0] mc);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> TEMPER_U);
    y = y ^ ((y << TEMPER_S) & mb);
    y = y ^ ((y << TEMPER_T) & mc);
    y = y ^ (y >> TEMPER_L);
    return y;
  endfunction

endpackage

[rtl/small_state_twister_rng.sv]
// ----------------------------------------------------------------------------
// small_state_twister_rng: small-state twister random word generator
// Expands a seed into a 19-word state and gives four tempered words per item.
// ----------------------------------------------------------------------------
// Usage:
// An item (seed, twist matrix word, two tempering masks) is taken at a rising
// edge where start is high and busy is low. Each item is independent of the
// ones before it.
// Seed expansion runs on one shared 32x32 multiplier, with a multiply step and
// then an add and store step for each of the 18 derived state words.
// Each output then takes two reads of the state memory (next word, tap word)
// and one twist, temper and write-back step; out_valid is registered after
// that step, and the fourth word of an item carries last.
// busy falls in the cycle the last word is shown, and a new item can be taken
// in that cycle. Results are shown for one cycle only and must be taken;
// there is no back-pressure. A synchronous reset (rst_n low) returns the
// sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module small_state_twister_rng (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sstr_pkg::in_item_t  in_item,
  output logic                out_valid,
  output sstr_pkg::out_item_t out_item
);
  import sstr_pkg::*;

  op_t        op;
  dp_status_t status;

  sstr_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy)
  );

  sstr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_item   (in_item),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

endmodule

[rtl/sstr_seq.sv]
// ----------------------------------------------------------------------------
// sstr_seq: microcode sequencer
// Steps through the control table, issues one datapath operation per cycle
// and takes conditional jumps on start and the datapath loop flags.
// ----------------------------------------------------------------------------
module sstr_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sstr_pkg::dp_status_t status,
  output sstr_pkg::op_t       op,
  output logic                busy
);
  import sstr_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ucode_t           uw;
  logic             taken;

  assign uw = ucode_rom(upc_r);

  always_comb begin
    case (uw.cond)
      COND_START:    taken = start;
      COND_EXP_MORE: taken = status.exp_more;
      COND_OUT_MORE: taken = status.out_more;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      upc_nxt = uw.target;
    end else if (uw.fin) begin
      upc_nxt = UPC_IDLE;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  // The load step only fires when an item is actually taken.
  always_comb begin
    if (uw.cond == COND_START && !start) begin
      op = OP_NOP;
    end else begin
      op = uw.op;
    end
  end

  assign busy = (upc_r != UPC_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[rtl/sstr_dp.sv]
// ----------------------------------------------------------------------------
// sstr_dp: generator datapath
// State word memory, seed expansion multiplier, twist logic, tempering and
// the result register, all driven by one operation code per cycle.
// ----------------------------------------------------------------------------
module sstr_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sstr_pkg::op_t        op,
  input  sstr_pkg::in_item_t   in_item,
  output sstr_pkg::dp_status_t status,
  output sstr_pkg::out_item_t  out_item,
  output logic                 out_valid
);
  import sstr_pkg::*;

  logic [31:0]       w_mem [STATE_WORDS];
  logic [31:0]       rdata_r;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [31:0]       wdata;

  logic [31:0]       p_r, prod_r, cur_r, nxt_r;
  logic [31:0]       ma_r, mb_r, mc_r;
  logic [IDX_W-1:0]  k_r, pos_r;
  logic [OCNT_W-1:0] ocnt_r;
  out_item_t         out_r;
  logic              out_valid_r;

  logic [IDX_W-1:0]  pn, pm;
  logic [IDX_W:0]    pm_sum;
  logic [31:0]       exp_word;
  logic [31:0]       y_mix, y_new;

  assign pn     = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);
  assign pm_sum = {1'b0, pos_r} + TAP_OFF;
  assign pm     = (pm_sum >= N_WIDE) ? IDX_W'(pm_sum - N_WIDE) : pm_sum[IDX_W-1:0];

  assign exp_word = prod_r + 32'(k_r);

  // The tap word arrives from the memory read issued in the previous step.
  assign y_mix = (cur_r & UPPER_MASK) | (nxt_r & LOWER_MASK);
  assign y_new = rdata_r ^ (y_mix >> 1) ^ (y_mix[0] ? ma_r : 32'd0);

  assign status.exp_more = (k_r != LAST_IDX);
  assign status.out_more = (ocnt_r != LAST_OUT);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = exp_word;
    raddr = pn;
    case (op)
      OP_LOAD: begin
        we    = 1'b1;
        wdata = in_item.seed;
      end
      OP_EXP_ADD: begin
        we    = 1'b1;
        waddr = k_r;
      end
      OP_RD_TAP: begin
        raddr = pm;
      end
      OP_TWIST: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = y_new;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      w_mem[waddr] <= wdata;
    end
    rdata_r <= w_mem[raddr];
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        p_r   <= in_item.seed;
        cur_r <= in_item.seed;
        ma_r  <= in_item.twist_word;
        mb_r  <= in_item.mask_b;
        mc_r  <= in_item.mask_c;
      end
      OP_EXP_MUL: begin
        prod_r <= SEED_MULT * (p_r ^ (p_r >> INIT_SHIFT));
      end
      OP_EXP_ADD: begin
        p_r <= exp_word;
      end
      OP_RD_TAP: begin
        nxt_r <= rdata_r;
      end
      OP_TWIST: begin
        cur_r             <= nxt_r;
        out_r.random_word <= temper(y_new, mb_r, mc_r);
        out_r.word_index  <= ocnt_r[1:0];
        out_r.last        <= (ocnt_r == LAST_OUT);
      end
      default: begin
        p_r <= p_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      pos_r       <= '0;
      ocnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (op == OP_TWIST);
      case (op)
        OP_LOAD: begin
          k_r    <= IDX_W'(1);
          pos_r  <= '0;
          ocnt_r <= '0;
        end
        OP_EXP_ADD: begin
          if (status.exp_more) begin
            k_r <= k_r + IDX_W'(1);
          end
        end
        OP_TWIST: begin
          pos_r  <= pn;
          ocnt_r <= ocnt_r + OCNT_W'(1);
        end
        default: begin
          k_r <= k_r;
        end
      endcase
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

[test/small_state_twister_rng_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// small_state_twister_rng_tb: self-checking bench for the twister generator
// Sends generator descriptions (seed, twist word, tempering masks) with random
// gaps and predicts the four tempered words of each item. A scoreboard checks
// every strobed word in order against the predictions.
// ----------------------------------------------------------------------------
module small_state_twister_rng_tb;
  import sstr_pkg::*;

  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  class word_scoreboard;
    out_item_t pending_words[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function logic [31:0] tempered(logic [31:0] y, logic [31:0] mb, logic [31:0] mc);
      logic [31:0] t;
      t = y ^ (y >> TEMPER_U);
      t = t ^ ((t << TEMPER_S) & mb);
      t = t ^ ((t << TEMPER_T) & mc);
      t = t ^ (t >> TEMPER_L);
      return t;
    endfunction

    // Rebuilds the whole state from the seed, then runs the twist steps.
    function void note_item(in_item_t item);
      logic [31:0] st [STATE_WORDS];
      logic [31:0] cur;
      logic [31:0] nxt;
      logic [31:0] tap;
      logic [31:0] y;
      int          pos;
      int          pn;
      int          pm;
      out_item_t   word;
      st[0] = item.seed;
      for (int k = 1; k < STATE_WORDS; k++) begin
        st[k] = SEED_MULT * (st[k-1] ^ (st[k-1] >> INIT_SHIFT)) + 32'(k);
      end
      pos = 0;
      nxt = st[0];
      for (int k = 0; k < OUTPUTS_PER_SEED; k++) begin
        pn  = (pos + 1) % STATE_WORDS;
        pm  = (pos + TAP_OFFSET) % STATE_WORDS;
        cur = nxt;
        nxt = st[pn];
        tap = st[pm];
        y   = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
        y   = tap ^ (y >> 1) ^ (y[0] ? item.twist_word : 32'h0);
        // The twisted word goes back into the state so later taps see it.
        st[pos] = y;
        pos = pn;
        word.random_word = tempered(y, item.mask_b, item.mask_c);
        word.word_index  = 2'(k);
        word.last        = (k == OUTPUTS_PER_SEED - 1);
        pending_words = {pending_words, word};
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected word: random_word %h word_index %0d last %0b",
               got.random_word, got.word_index, got.last);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.random_word !== want.random_word) begin
        $error("random_word: expected %h actual %h", want.random_word, got.random_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d actual %0d", want.word_index, got.word_index);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  word_scoreboard board;
  int             quiet_cycles = 0;

  small_state_twister_rng i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  // Output monitor and watchdog share the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_word(out_item);
    end
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("small_state_twister_rng: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, some medium ones and a few long enough to outlast busy.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) begin
      return $urandom_range(0, 3);
    end else if (roll < 18) begin
      return $urandom_range(4, 30);
    end
    return $urandom_range(31, 120);
  endfunction

  function automatic logic [31:0] random_field();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // The item stays on the inputs until an edge finds busy low.
  task automatic send_item(input in_item_t item, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    board.note_item(item);
  endtask

  initial begin
    in_item_t item;
    int       gap;
    board = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items: field extremes, a zero seed and the classic masks.
    send_item('{32'h0000_0000, 32'h9908_B0DF, 32'h9D2C_5680, 32'hEFC6_0000}, pick_gap());
    send_item('{32'hFFFF_FFFF, 32'h9908_B0DF, 32'h9D2C_5680, 32'hEFC6_0000}, 0);
    send_item('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 0);
    send_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, pick_gap());
    send_item('{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF}, pick_gap());
    send_item('{32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000}, 0);
    send_item('{32'h0000_1571, 32'h9908_B0DF, 32'h9D2C_5680, 32'hEFC6_0000}, pick_gap());
    send_item('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, pick_gap());
    send_item('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 0);
    send_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000}, pick_gap());
    send_item('{32'hFFFF_FFFE, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001}, 0);
    send_item('{32'h1234_5678, 32'hDEAD_BEEF, 32'hF0F0_F0F0, 32'h0F0F_0F0F}, pick_gap());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      item.seed       = $urandom();
      item.twist_word = random_field();
      item.mask_b     = random_field();
      item.mask_c     = random_field();
      // Every third block of items runs back to back with start held high.
      gap = (((n / 50) % 3) == 1) ? 0 : pick_gap();
      send_item(item, gap);
    end
    @(negedge clk);
    start <= 1'b0;

    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("small_state_twister_rng: match");
    end else begin
      $display("small_state_twister_rng: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sstr_pkg.sv
rtl/sstr_seq.sv
rtl/sstr_dp.sv
rtl/small_state_twister_rng.sv
test/small_state_twister_rng_tb.sv
